/* rtl/core/rtcbm_pkg.sv */
package rtcbm_pkg;

    localparam int WRITE_BYTES    = 8;
    localparam int READ_BYTES     = 7;
    localparam int READ_BUF_BYTES = 7;
    localparam int MODE_READ_BIT  = 1;

    localparam logic [1:0] MODE_UNLOCK = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [7:0] CMD_WP_REG   = 8'h8E;
    localparam logic [7:0] WP_CLEAR     = 8'h00;
    localparam logic [7:0] CMD_BURST_WR = 8'hBE;
    localparam logic [7:0] CMD_BURST_RD = 8'hBF;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_U_ON  = 4'd1,
        PH_U_TX  = 4'd2,
        PH_U_OFF = 4'd3,
        PH_W_ON  = 4'd4,
        PH_W_TX  = 4'd5,
        PH_W_OFF = 4'd6,
        PH_R_ON  = 4'd7,
        PH_R_TX  = 4'd8,
        PH_R_RX  = 4'd9,
        PH_R_OFF = 4'd10
    } phase_t;

    typedef struct packed {
        phase_t       phase;
        logic [1:0]   op_mode;
        logic [2:0]   bit_count;
        logic [3:0]   byte_count;
        logic         clock_half;
        logic [7:0]   shift_byte;
        logic [63:0]  write_buffer;
        logic [55:0]  read_buffer;
    } seq_state_t;

    typedef struct packed {
        logic         chip_enable;
        logic         serial_clock;
        logic         data_out;
        logic         data_drive;
        logic         busy_res;
        logic         done_res;
        logic [55:0]  read_data;
    } pins_t;

    function automatic logic [7:0] frame_byte(phase_t phase, logic [3:0] idx,
                                              logic [63:0] wb);
        logic [7:0] b;
        b = CMD_BURST_RD;
        if (phase == PH_U_TX)
        begin
            b = (idx == 4'd0) ? CMD_WP_REG : WP_CLEAR;
        end
        else if (phase == PH_W_TX)
        begin
            if (idx == 4'd0)
            begin
                b = CMD_BURST_WR;
            end
            else if (idx > 4'd8)
            begin
                b = 8'h00;
            end
            else
            begin
                b = wb[{idx[2:0] - 3'd1, 3'b000} +: 8];
            end
        end
        return b;
    endfunction

    function automatic logic [3:0] frame_len(phase_t phase);
        logic [3:0] n;
        n = 4'd1;
        if (phase == PH_U_TX)
        begin
            n = 4'd2;
        end
        else if (phase == PH_W_TX)
        begin
            n = 4'(WRITE_BYTES + 1);
        end
        return n;
    endfunction

endpackage

/* rtl/core/rtcbm_step.sv */
module rtcbm_step (
    input  rtcbm_pkg::seq_state_t cur,
    input  logic                  start_req,
    input  logic [1:0]            mode,
    input  logic [63:0]           write_data,
    input  logic                  io_in,
    output rtcbm_pkg::seq_state_t nxt,
    output rtcbm_pkg::pins_t      pins
);

    logic [3:0] bc_inc;
    logic       done;

    assign bc_inc = cur.byte_count + 4'd1;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        case (cur.phase)
            rtcbm_pkg::PH_U_ON, rtcbm_pkg::PH_W_ON, rtcbm_pkg::PH_R_ON:
            begin
                case (cur.phase)
                    rtcbm_pkg::PH_U_ON: nxt.phase = rtcbm_pkg::PH_U_TX;
                    rtcbm_pkg::PH_W_ON: nxt.phase = rtcbm_pkg::PH_W_TX;
                    default:            nxt.phase = rtcbm_pkg::PH_R_TX;
                endcase
                nxt.clock_half = 1'b0;
                nxt.bit_count  = 3'd0;
                nxt.byte_count = 4'd0;
                nxt.shift_byte = rtcbm_pkg::frame_byte(nxt.phase, 4'd0, cur.write_buffer);
            end
            rtcbm_pkg::PH_U_TX, rtcbm_pkg::PH_W_TX, rtcbm_pkg::PH_R_TX:
            begin
                if (!cur.clock_half)
                begin
                    nxt.clock_half = 1'b1;
                end
                else
                begin
                    nxt.clock_half = 1'b0;
                    nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
                    if (cur.bit_count == 3'd7)
                    begin
                        nxt.bit_count  = 3'd0;
                        nxt.byte_count = bc_inc;
                        if (bc_inc < rtcbm_pkg::frame_len(cur.phase))
                        begin
                            nxt.shift_byte = rtcbm_pkg::frame_byte(cur.phase, bc_inc,
                                                                   cur.write_buffer);
                        end
                        else if (cur.phase == rtcbm_pkg::PH_R_TX)
                        begin
                            nxt.phase      = rtcbm_pkg::PH_R_RX;
                            nxt.byte_count = 4'd0;
                            nxt.shift_byte = 8'h00;
                        end
                        else if (cur.phase == rtcbm_pkg::PH_U_TX)
                        begin
                            nxt.phase = rtcbm_pkg::PH_U_OFF;
                        end
                        else
                        begin
                            nxt.phase = rtcbm_pkg::PH_W_OFF;
                        end
                    end
                    else
                    begin
                        nxt.bit_count = cur.bit_count + 3'd1;
                    end
                end
            end
            rtcbm_pkg::PH_R_RX:
            begin
                if (!cur.clock_half)
                begin
                    nxt.shift_byte = {io_in, cur.shift_byte[7:1]};
                    nxt.clock_half = 1'b1;
                end
                else
                begin
                    nxt.clock_half = 1'b0;
                    if (cur.bit_count == 3'd7)
                    begin
                        nxt.bit_count = 3'd0;
                        if (cur.byte_count < 4'(rtcbm_pkg::READ_BUF_BYTES))
                        begin
                            nxt.read_buffer[{cur.byte_count[2:0], 3'b000} +: 8] =
                                cur.shift_byte;
                        end
                        nxt.byte_count = bc_inc;
                        nxt.shift_byte = 8'h00;
                        if (bc_inc >= 4'(rtcbm_pkg::READ_BYTES))
                        begin
                            nxt.phase = rtcbm_pkg::PH_R_OFF;
                        end
                    end
                    else
                    begin
                        nxt.bit_count = cur.bit_count + 3'd1;
                    end
                end
            end
            rtcbm_pkg::PH_U_OFF:
            begin
                if (cur.op_mode == rtcbm_pkg::MODE_WRITE)
                begin
                    nxt.phase = rtcbm_pkg::PH_W_ON;
                end
                else
                begin
                    nxt.phase = rtcbm_pkg::PH_IDLE;
                    done      = 1'b1;
                end
            end
            rtcbm_pkg::PH_W_OFF, rtcbm_pkg::PH_R_OFF:
            begin
                nxt.phase = rtcbm_pkg::PH_IDLE;
                done      = 1'b1;
            end
            default:
            begin
                nxt.phase = rtcbm_pkg::PH_IDLE;
                if (start_req)
                begin
                    nxt.op_mode      = mode;
                    nxt.write_buffer = write_data;
                    nxt.bit_count    = 3'd0;
                    nxt.byte_count   = 4'd0;
                    nxt.clock_half   = 1'b0;
                    nxt.shift_byte   = 8'h00;
                    if (mode[rtcbm_pkg::MODE_READ_BIT])
                    begin
                        nxt.read_buffer = 56'd0;
                        nxt.phase       = rtcbm_pkg::PH_R_ON;
                    end
                    else
                    begin
                        nxt.phase = rtcbm_pkg::PH_U_ON;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        pins           = '0;
        pins.done_res  = done;
        pins.read_data = nxt.read_buffer;
        case (nxt.phase)
            rtcbm_pkg::PH_U_ON, rtcbm_pkg::PH_W_ON, rtcbm_pkg::PH_R_ON:
            begin
                pins.chip_enable = 1'b1;
                pins.data_drive  = 1'b1;
                pins.busy_res    = 1'b1;
            end
            rtcbm_pkg::PH_U_TX, rtcbm_pkg::PH_W_TX, rtcbm_pkg::PH_R_TX:
            begin
                pins.chip_enable  = 1'b1;
                pins.serial_clock = nxt.clock_half;
                pins.data_out     = nxt.shift_byte[0];
                pins.data_drive   = 1'b1;
                pins.busy_res     = 1'b1;
            end
            rtcbm_pkg::PH_R_RX:
            begin
                pins.chip_enable  = 1'b1;
                pins.serial_clock = nxt.clock_half;
                pins.busy_res     = 1'b1;
            end
            rtcbm_pkg::PH_U_OFF, rtcbm_pkg::PH_W_OFF, rtcbm_pkg::PH_R_OFF:
            begin
                pins.busy_res = 1'b1;
            end
            default:
            begin
                pins.busy_res = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/three_wire_rtc_burst_master.sv */
// Three-wire real-time-clock burst master, one half-bit step per input word.
// Input channel (in_valid/in_ready): start_req, mode, write_data and the
// sampled data pin io_in. Each accepted word advances the sequencer by one
// half-bit step and yields exactly one output word on the output channel
// (out_valid/out_ready): pin levels chip_enable, serial_clock, data_out,
// data_drive, plus busy_res, done_res and read_data.
// Latency: the output word for an input word is valid in the cycle after
// acceptance. Throughput: one word per cycle; the sequencer state register
// and the output register are updated together, with the step logic between.
// A start request is taken only while idle; mode 0 unlocks write protect,
// mode 1 unlocks then burst-writes eight bytes, mode 2 or 3 burst-reads
// seven bytes into read_data.
// Reset: the sequencer returns to idle with all counters and buffers cleared
// and no output word pending.
// Stall: while out_ready is low with a word pending, in_ready stays low and
// the output word holds; a new input word is taken in the same cycle the
// pending word is taken.
module three_wire_rtc_burst_master (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         start_req,
    input  logic [1:0]   mode,
    input  logic [63:0]  write_data,
    input  logic         io_in,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         chip_enable,
    output logic         serial_clock,
    output logic         data_out,
    output logic         data_drive,
    output logic         busy_res,
    output logic         done_res,
    output logic [55:0]  read_data
);

    rtcbm_pkg::seq_state_t state_reg;
    rtcbm_pkg::seq_state_t state_next;
    rtcbm_pkg::pins_t      pins_reg;
    rtcbm_pkg::pins_t      pins_next;
    logic                  out_valid_reg;
    logic                  in_take;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    rtcbm_step u_step (
        .cur        (state_reg),
        .start_req  (start_req),
        .mode       (mode),
        .write_data (write_data),
        .io_in      (io_in),
        .nxt        (state_next),
        .pins       (pins_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= rtcbm_pkg::PH_IDLE;
            state_reg.op_mode      <= rtcbm_pkg::MODE_UNLOCK;
            state_reg.bit_count    <= 3'd0;
            state_reg.byte_count   <= 4'd0;
            state_reg.clock_half   <= 1'b0;
            state_reg.shift_byte   <= 8'h00;
            state_reg.write_buffer <= 64'd0;
            state_reg.read_buffer  <= 56'd0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg <= state_next;
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pins_reg <= pins_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_enable  = pins_reg.chip_enable;
    assign serial_clock = pins_reg.serial_clock;
    assign data_out     = pins_reg.data_out;
    assign data_drive   = pins_reg.data_drive;
    assign busy_res     = pins_reg.busy_res;
    assign done_res     = pins_reg.done_res;
    assign read_data    = pins_reg.read_data;

endmodule

/* rtl/core/rtcbm_checker.sv */
module rtcbm_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic         chip_enable,
    input  logic         serial_clock,
    input  logic         data_out,
    input  logic         data_drive,
    input  logic         busy_res,
    input  logic         done_res,
    input  logic [55:0]  read_data
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(chip_enable) && $stable(serial_clock))
        else $error("stalled output word changed");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !chip_enable)
        else $error("done pulse while busy");

    a_clk_ce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && serial_clock |-> chip_enable)
        else $error("serial clock high outside a frame");

    a_undriven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_drive |-> !data_out)
        else $error("data_out set while pin undriven");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word gave no output word");

endmodule

bind three_wire_rtc_burst_master rtcbm_checker u_rtcbm_checker (.*);

/* tb/three_wire_rtc_burst_master_tb.sv */
`timescale 1ns / 100ps

module three_wire_rtc_burst_master_tb;

    localparam int WORDS_PER_PHASE = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_LIMIT     = 5000;

    localparam int IO_LOW  = 0;
    localparam int IO_HIGH = 1;
    localparam int IO_RAND = 2;

    class rtc_pin_scoreboard;
        rtcbm_pkg::phase_t ph;
        logic [1:0]        opm;
        logic [2:0]        bitn;
        logic [3:0]        byten;
        logic              half;
        logic [7:0]        sreg;
        logic [63:0]       wbuf;
        logic [55:0]       rbuf;
        rtcbm_pkg::pins_t  pins_due[$];
        int                mismatches;

        function new();
            ph         = rtcbm_pkg::PH_IDLE;
            opm        = rtcbm_pkg::MODE_UNLOCK;
            bitn       = '0;
            byten      = '0;
            half       = 1'b0;
            sreg       = '0;
            wbuf       = '0;
            rbuf       = '0;
            mismatches = 0;
        endfunction

        function logic [3:0] bytes_in_frame(rtcbm_pkg::phase_t p);
            if (p == rtcbm_pkg::PH_U_TX)
                return 4'd2;
            if (p == rtcbm_pkg::PH_W_TX)
                return 4'(rtcbm_pkg::WRITE_BYTES + 1);
            return 4'd1;
        endfunction

        function logic [7:0] tx_byte(rtcbm_pkg::phase_t p, logic [3:0] idx);
            if (p == rtcbm_pkg::PH_U_TX)
                return (idx == 4'd0) ? rtcbm_pkg::CMD_WP_REG : rtcbm_pkg::WP_CLEAR;
            if (p == rtcbm_pkg::PH_W_TX)
            begin
                if (idx == 4'd0)
                    return rtcbm_pkg::CMD_BURST_WR;
                if (idx > 4'd8)
                    return 8'h00;
                return wbuf[8 * (int'(idx) - 1) +: 8];
            end
            return rtcbm_pkg::CMD_BURST_RD;
        endfunction

        function void open_frame(rtcbm_pkg::phase_t p);
            ph    = p;
            half  = 1'b0;
            bitn  = '0;
            byten = '0;
            sreg  = tx_byte(p, 4'd0);
        endfunction

        function rtcbm_pkg::pins_t next_pins(logic start, logic [1:0] md,
                                             logic [63:0] wd, logic io);
            rtcbm_pkg::pins_t r;
            r = '0;
            case (ph)
                rtcbm_pkg::PH_U_ON: open_frame(rtcbm_pkg::PH_U_TX);
                rtcbm_pkg::PH_W_ON: open_frame(rtcbm_pkg::PH_W_TX);
                rtcbm_pkg::PH_R_ON: open_frame(rtcbm_pkg::PH_R_TX);
                rtcbm_pkg::PH_U_TX, rtcbm_pkg::PH_W_TX, rtcbm_pkg::PH_R_TX:
                begin
                    if (!half)
                    begin
                        half = 1'b1;
                    end
                    else
                    begin
                        half = 1'b0;
                        sreg = sreg >> 1;
                        if (bitn == 3'd7)
                        begin
                            bitn  = '0;
                            byten = byten + 4'd1;
                            if (byten < bytes_in_frame(ph))
                            begin
                                sreg = tx_byte(ph, byten);
                            end
                            else if (ph == rtcbm_pkg::PH_R_TX)
                            begin
                                ph    = rtcbm_pkg::PH_R_RX;
                                byten = '0;
                                sreg  = '0;
                            end
                            else if (ph == rtcbm_pkg::PH_U_TX)
                            begin
                                ph = rtcbm_pkg::PH_U_OFF;
                            end
                            else
                            begin
                                ph = rtcbm_pkg::PH_W_OFF;
                            end
                        end
                        else
                        begin
                            bitn = bitn + 3'd1;
                        end
                    end
                end
                rtcbm_pkg::PH_R_RX:
                begin
                    if (!half)
                    begin
                        sreg = {io, sreg[7:1]};
                        half = 1'b1;
                    end
                    else
                    begin
                        half = 1'b0;
                        if (bitn == 3'd7)
                        begin
                            bitn = '0;
                            if (byten < 4'(rtcbm_pkg::READ_BUF_BYTES))
                                rbuf[8 * int'(byten) +: 8] = sreg;
                            byten = byten + 4'd1;
                            sreg  = '0;
                            if (byten >= 4'(rtcbm_pkg::READ_BYTES))
                                ph = rtcbm_pkg::PH_R_OFF;
                        end
                        else
                        begin
                            bitn = bitn + 3'd1;
                        end
                    end
                end
                rtcbm_pkg::PH_U_OFF:
                begin
                    if (opm == rtcbm_pkg::MODE_WRITE)
                    begin
                        ph = rtcbm_pkg::PH_W_ON;
                    end
                    else
                    begin
                        ph         = rtcbm_pkg::PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                rtcbm_pkg::PH_W_OFF, rtcbm_pkg::PH_R_OFF:
                begin
                    ph         = rtcbm_pkg::PH_IDLE;
                    r.done_res = 1'b1;
                end
                default:
                begin
                    ph = rtcbm_pkg::PH_IDLE;
                    if (start)
                    begin
                        opm   = md;
                        wbuf  = wd;
                        bitn  = '0;
                        byten = '0;
                        half  = 1'b0;
                        sreg  = '0;
                        if (md[rtcbm_pkg::MODE_READ_BIT])
                        begin
                            rbuf = '0;
                            ph   = rtcbm_pkg::PH_R_ON;
                        end
                        else
                        begin
                            ph = rtcbm_pkg::PH_U_ON;
                        end
                    end
                end
            endcase

            case (ph)
                rtcbm_pkg::PH_U_ON, rtcbm_pkg::PH_W_ON, rtcbm_pkg::PH_R_ON:
                begin
                    r.chip_enable = 1'b1;
                    r.data_drive  = 1'b1;
                    r.busy_res    = 1'b1;
                end
                rtcbm_pkg::PH_U_TX, rtcbm_pkg::PH_W_TX, rtcbm_pkg::PH_R_TX:
                begin
                    r.chip_enable  = 1'b1;
                    r.serial_clock = half;
                    r.data_out     = sreg[0];
                    r.data_drive   = 1'b1;
                    r.busy_res     = 1'b1;
                end
                rtcbm_pkg::PH_R_RX:
                begin
                    r.chip_enable  = 1'b1;
                    r.serial_clock = half;
                    r.busy_res     = 1'b1;
                end
                rtcbm_pkg::PH_U_OFF, rtcbm_pkg::PH_W_OFF, rtcbm_pkg::PH_R_OFF:
                begin
                    r.busy_res = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.read_data = rbuf;
            return r;
        endfunction

        function void note_word(logic start, logic [1:0] md, logic [63:0] wd, logic io);
            pins_due.push_back(next_pins(start, md, wd, io));
        endfunction

        function void check_pins(rtcbm_pkg::pins_t got);
            rtcbm_pkg::pins_t want;
            if (pins_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output word %h", $realtime, got);
                return;
            end
            want = pins_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pins expected %b%b%b%b%b%b %h, got %b%b%b%b%b%b %h",
                             $realtime, want.chip_enable, want.serial_clock, want.data_out,
                             want.data_drive, want.busy_res, want.done_res, want.read_data,
                             got.chip_enable, got.serial_clock, got.data_out,
                             got.data_drive, got.busy_res, got.done_res, got.read_data);
            end
        endfunction

        function bit idle();
            return ph == rtcbm_pkg::PH_IDLE;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction
    endclass

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             start_req  = 1'b0;
    logic [1:0]       mode       = rtcbm_pkg::MODE_UNLOCK;
    logic [63:0]      write_data = '0;
    logic             io_in      = 1'b0;
    logic             out_ready  = 1'b0;
    logic             in_ready;
    logic             out_valid;
    logic             chip_enable;
    logic             serial_clock;
    logic             data_out;
    logic             data_drive;
    logic             busy_res;
    logic             done_res;
    logic [55:0]      read_data;
    rtcbm_pkg::pins_t seen_pins;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_left = 0;

    rtc_pin_scoreboard sb;

    three_wire_rtc_burst_master dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .mode         (mode),
        .write_data   (write_data),
        .io_in        (io_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chip_enable  (chip_enable),
        .serial_clock (serial_clock),
        .data_out     (data_out),
        .data_drive   (data_drive),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data)
    );

    assign seen_pins = {chip_enable, serial_clock, data_out, data_drive,
                        busy_res, done_res, read_data};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hold off for a long stretch when asked, else stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pins(seen_pins);
    end

    initial
    begin
        #400000;
        $display("** three_wire_rtc_burst_master: FAILED **");
        $finish;
    end

    task automatic send_word(logic s, logic [1:0] md, logic [63:0] wd, logic io);
        in_valid   <= 1'b1;
        start_req  <= s;
        mode       <= md;
        write_data <= wd;
        io_in      <= io;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(s, md, wd, io);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // open a frame, then keep stepping it to its done word
    task automatic run_frame(logic [1:0] md, logic [63:0] wd, int io_kind, bit noise);
        logic io;
        send_word(1'b1, md, wd, 1'b0);
        while (!sb.idle())
        begin
            io = (io_kind == IO_RAND) ? 1'($urandom) : (io_kind == IO_HIGH);
            if (noise)
                send_word(1'b1, ~md, ~wd, io);
            else
                send_word(1'b0, rtcbm_pkg::MODE_UNLOCK, '0, io);
        end
    endtask

    initial
    begin
        int drain;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(1'b0, 2'b11, '1, 1'b1);
        send_word(1'b0, rtcbm_pkg::MODE_UNLOCK, '0, 1'b0);
        run_frame(rtcbm_pkg::MODE_UNLOCK, '0, IO_LOW, 1'b0);
        run_frame(rtcbm_pkg::MODE_WRITE, '1, IO_HIGH, 1'b1);
        run_frame(rtcbm_pkg::MODE_WRITE, '0, IO_LOW, 1'b0);
        run_frame(rtcbm_pkg::MODE_READ, '1, IO_HIGH, 1'b0);
        run_frame(2'b11, '0, IO_LOW, 1'b1);
        run_frame(rtcbm_pkg::MODE_READ, {$urandom, $urandom}, IO_RAND, 1'b0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  hold_left = HOLD_OFF_CYCLES; end
                1: begin snd_idle_pct = 49; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 49; end
                default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word($urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)),
                          {$urandom, $urandom}, 1'($urandom));
        end
        in_valid <= 1'b0;

        drain = 0;
        while (sb.pending() > 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.pending() > 0)
        begin
            sb.mismatches++;
            $display("%0t: %0d output words never arrived", $realtime, sb.pending());
        end
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("** three_wire_rtc_burst_master: PASSED **");
        else
            $display("** three_wire_rtc_burst_master: FAILED **");
        $finish;
    end

endmodule
